/* hdl/ttwm_pkg.sv */
// Shared constants, payload types and register codes of the tiled triangle wipe mask.
`default_nettype none
package ttwm_pkg;

  // Screen size in tiles.
  localparam int TILE_COLUMNS = 32;
  localparam int TILE_ROWS    = 28;
  localparam int HALF_W       = 4 * TILE_COLUMNS;
  localparam int HALF_H       = 4 * TILE_ROWS;

  // Signed forms used by the offset arithmetic.
  localparam logic signed [9:0] HALF_W_S    = 10'(HALF_W);
  localparam logic signed [9:0] HALF_H_S    = 10'(HALF_H);
  localparam logic signed [9:0] COLS_M1_S   = 10'(TILE_COLUMNS - 1);
  localparam logic signed [9:0] ROWS_M1_S   = 10'(TILE_ROWS - 1);
  localparam logic signed [9:0] HALF_COLS_S = 10'(TILE_COLUMNS / 2);
  localparam logic signed [9:0] HALF_ROWS_S = 10'(TILE_ROWS / 2);

  // Fill index arithmetic.
  localparam logic [5:0]        FULL_BASE = 6'd31;
  localparam logic signed [7:0] FILL_BIAS = 8'sd15;
  localparam logic [3:0]        FILL_MAX  = 4'd15;
  localparam logic [3:0]        BYTES_MAX = 4'd8;

  // Masked pixel value, replicated over the line word.
  localparam logic [63:0] PIX_ALL  = 64'hFDFD_FDFD_FDFD_FDFD;
  localparam logic [7:0]  PIX_BYTE = PIX_ALL[7:0];

  // Configuration register indexes.
  localparam logic [1:0] REG_CENTER_X  = 2'd0;
  localparam logic [1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [1:0] REG_MAX_LEVEL = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] CENTER_X_RST  = 8'd128;
  localparam logic [7:0] CENTER_Y_RST  = 8'd112;
  localparam logic [6:0] MAX_LEVEL_RST = 7'd66;

  // Per-line facts that ride alongside the divider.
  typedef struct packed {
    logic [4:0] d;
    logic [4:0] cdist;
    logic       lower;
    logic       left;
    logic [2:0] line;
  } side_t;

  // Divider stage payload: partial remainder, quotient so far, divisor.
  typedef struct packed {
    logic [12:0] rem;
    logic [5:0]  quo;
    logic [6:0]  dvsr;
    side_t       side;
  } div_t;

  // Front stage payload.
  typedef struct packed {
    logic [5:0] k;
    logic [6:0] diff;
    logic [6:0] mx;
    side_t      side;
  } front_t;

endpackage
`default_nettype wire

/* hdl/ttwm_if.sv */
// Channel interfaces of the tiled triangle wipe mask: request, mask result and configuration.
`default_nettype none
interface ttwm_req_if;
  logic       valid;
  logic       ready;
  logic [4:0] tile_row;
  logic [4:0] tile_col;
  logic [2:0] line_in_tile;
  logic [6:0] level;
  modport source (output valid, output tile_row, output tile_col,
                  output line_in_tile, output level, input ready);
  modport sink   (input valid, input tile_row, input tile_col,
                  input line_in_tile, input level, output ready);
endinterface

interface ttwm_mask_if;
  logic        valid;
  logic        ready;
  logic [63:0] line_word;
  modport source (output valid, output line_word, input ready);
  modport sink   (input valid, input line_word, output ready);
endinterface

interface ttwm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/tiled_triangle_wipe_mask_top.sv */
// Top level of the tiled triangle wipe mask: six-stage pipeline from tile line to mask word.
//
// The block turns one request item (tile row, tile column, line within the tile and a
// wipe level) into one mask item: a 64-bit line word whose byte k is 0xFD where pixel k
// is covered by the wipe and 0 where it is not. Both channels use valid/ready; an item
// moves at a rising edge where both are high.
// The configuration channel writes center_x (index 0), center_y (index 1) and max_level
// (index 2); it is always ready and other indexes are dropped. Write it only while no
// item is in flight. A max_level of 0 behaves as 1.
// An accepted request is registered in turn by stage 0, stage 1, the three divider stages
// and the output word register, which presents the mask item to the receiver.
// Throughput is one item per cycle while the receiver does not stall: every stage holds
// one item, and the 13-by-7 bit division of the fill scale is a restoring divider spread
// over three stages, two quotient bits each, so nothing in the path iterates in place.
// When the receiver stalls, each stage holds its item and the pipeline keeps filling its
// empty stages; request ready falls only once every stage is occupied, so up to six
// items can be queued inside. Nothing is dropped or repeated across a stall.
// Synchronous reset empties all stages and restores center 128/112 and max_level 66.
`default_nettype none
module tiled_triangle_wipe_mask_top (
  input  wire logic    clk,
  input  wire logic    rst,
  ttwm_cfg_if.sink     cfg,
  ttwm_req_if.sink     req,
  ttwm_mask_if.source  mask
);

  // Configuration registers.
  logic [7:0] center_x;
  logic [7:0] center_y;
  logic [6:0] max_level;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= ttwm_pkg::CENTER_X_RST;
      center_y  <= ttwm_pkg::CENTER_Y_RST;
      max_level <= ttwm_pkg::MAX_LEVEL_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ttwm_pkg::REG_CENTER_X:  center_x  <= cfg.data;
        ttwm_pkg::REG_CENTER_Y:  center_y  <= cfg.data;
        ttwm_pkg::REG_MAX_LEVEL: max_level <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage takes a new item when it is empty or its item moves on.
  logic v0, v1, v5;
  logic r0, r1, r5;
  logic rdy2, rdy3, rdy4;
  logic v2, v3, v4;

  // Stage 0: tile offsets, diamond distance, quadrant and level clamp.
  logic signed [9:0] sx, sy, sx_adj, sy_adj, xo, yo;
  logic signed [9:0] row_s, col_s, tx, ty, ax, ay;
  logic [4:0]        dxt, dyt;
  logic [7:0]        cdx, cdy, cmax;
  logic [6:0]        mx, a_cl;
  ttwm_pkg::front_t  front_next;
  ttwm_pkg::front_t  front;

  always_comb begin
    sx     = signed'({2'b00, center_x}) - ttwm_pkg::HALF_W_S;
    sy     = signed'({2'b00, center_y}) - ttwm_pkg::HALF_H_S;
    // Division by eight that truncates toward zero.
    sx_adj = sx + (sx[9] ? 10'sd7 : 10'sd0);
    sy_adj = sy + (sy[9] ? 10'sd7 : 10'sd0);
    xo     = sx_adj >>> 3;
    yo     = sy_adj >>> 3;
    row_s  = signed'({5'b00000, req.tile_row});
    col_s  = signed'({5'b00000, req.tile_col});
    tx     = ttwm_pkg::COLS_M1_S - (col_s <<< 1) + (xo <<< 1);
    ty     = ttwm_pkg::ROWS_M1_S - (row_s <<< 1) + (yo <<< 1);
    ax     = tx[9] ? -tx : tx;
    ay     = ty[9] ? -ty : ty;
    dxt    = ax[5:1];
    dyt    = ay[5:1];

    cdx  = (center_x >= 8'(ttwm_pkg::HALF_W)) ? center_x - 8'(ttwm_pkg::HALF_W)
                                               : 8'(ttwm_pkg::HALF_W) - center_x;
    cdy  = (center_y >= 8'(ttwm_pkg::HALF_H)) ? center_y - 8'(ttwm_pkg::HALF_H)
                                               : 8'(ttwm_pkg::HALF_H) - center_y;
    cmax = (cdx > cdy) ? cdx : cdy;

    mx   = (max_level == 7'd0) ? 7'd1 : max_level;
    a_cl = (req.level > mx) ? mx : req.level;

    // The distance never exceeds 31, so it fits the 5-bit d field.
    front_next.side.d     = (dxt > dyt) ? dxt : dyt;
    front_next.side.cdist = cmax[7:3];
    front_next.side.lower = (row_s - yo) >= ttwm_pkg::HALF_ROWS_S;
    front_next.side.left  = (col_s - xo) < ttwm_pkg::HALF_COLS_S;
    front_next.side.line  = req.line_in_tile;
    front_next.k          = ttwm_pkg::FULL_BASE + {1'b0, cmax[7:3]};
    front_next.diff       = mx - a_cl;
    front_next.mx         = mx;
  end

  assign r0        = !v0 || r1;
  assign req.ready = r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (r0) begin
      v0 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && req.valid) begin
      front <= front_next;
    end
  end

  // Stage 1: scale product (31 + centre distance) * (max - level), at most 48 * 127.
  ttwm_pkg::div_t prod;

  assign r1 = !v1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && v0) begin
      prod.rem  <= {7'b0, front.k} * {6'b0, front.diff};
      prod.quo  <= 6'd0;
      prod.dvsr <= front.mx;
      prod.side <= front.side;
    end
  end

  // Stages 2 to 4: quotient bits 5..0. The quotient is at most 48, so six bits suffice.
  ttwm_pkg::div_t q2, q3, q4;

  ttwm_div_stage u_div_a (
    .clk       (clk),
    .rst       (rst),
    .top_bit   (3'd5),
    .in_valid  (v1),
    .in_ready  (rdy2),
    .in_data   (prod),
    .out_valid (v2),
    .out_ready (rdy3),
    .out_data  (q2)
  );

  ttwm_div_stage u_div_b (
    .clk       (clk),
    .rst       (rst),
    .top_bit   (3'd3),
    .in_valid  (v2),
    .in_ready  (rdy3),
    .in_data   (q2),
    .out_valid (v3),
    .out_ready (rdy4),
    .out_data  (q3)
  );

  ttwm_div_stage u_div_c (
    .clk       (clk),
    .rst       (rst),
    .top_bit   (3'd1),
    .in_valid  (v3),
    .in_ready  (rdy4),
    .in_data   (q3),
    .out_valid (v4),
    .out_ready (r5),
    .out_data  (q4)
  );

  // Stage 5: fill index, per-line byte count and the output word register.
  logic signed [7:0] v_raw;
  logic [3:0]        v_cl;
  logic [2:0]        lref;
  logic signed [5:0] n_raw;
  logic [3:0]        n_cnt;
  logic [63:0]       word_next;
  logic [63:0]       word;

  always_comb begin
    v_raw = signed'({2'b00, q4.quo}) + signed'({3'b000, q4.side.d})
            - ttwm_pkg::FILL_BIAS - signed'({3'b000, q4.side.cdist});
    if (v_raw < 8'sd0) begin
      v_cl = 4'd0;
    end else if (v_raw > signed'({4'b0000, ttwm_pkg::FILL_MAX})) begin
      v_cl = ttwm_pkg::FILL_MAX;
    end else begin
      v_cl = v_raw[3:0];
    end
    // In the lower half the triangle grows from the bottom line of the tile.
    lref  = q4.side.lower ? ~q4.side.line : q4.side.line;
    n_raw = signed'({2'b00, v_cl}) - signed'({3'b000, lref});
    if (n_raw < 6'sd0) begin
      n_cnt = 4'd0;
    end else if (n_raw > signed'({2'b00, ttwm_pkg::BYTES_MAX})) begin
      n_cnt = ttwm_pkg::BYTES_MAX;
    end else begin
      n_cnt = n_raw[3:0];
    end
    for (int b = 0; b < 8; b++) begin
      if (q4.side.left) begin
        word_next[8*b +: 8] = (4'(b) < n_cnt) ? ttwm_pkg::PIX_BYTE : 8'h00;
      end else begin
        word_next[8*b +: 8] = (({1'b0, 4'(b)} + {1'b0, n_cnt}) >= {1'b0, ttwm_pkg::BYTES_MAX})
                              ? ttwm_pkg::PIX_BYTE : 8'h00;
      end
    end
  end

  assign r5 = !v5 || mask.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (r5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      word <= word_next;
    end
  end

  assign mask.valid     = v5;
  assign mask.line_word = word;

  // A full pipeline facing a stalled receiver must refuse new requests.
  assert property (@(posedge clk) disable iff (rst)
    (v0 && v1 && v2 && v3 && v4 && v5 && !mask.ready) |-> !req.ready)
    else $error("request accepted while every stage is occupied and output is stalled");

  // The scale factor never exceeds one, so the quotient stays at or below 31 + 17.
  assert property (@(posedge clk) disable iff (rst)
    v4 |-> (q4.quo <= 6'd48))
    else $error("divider quotient out of range");

  // After reset no result is presented.
  assert property (@(posedge clk)
    rst |=> !mask.valid)
    else $error("mask item presented right after reset");

endmodule
`default_nettype wire

/* hdl/ttwm_div_stage.sv */
// One registered stage of the restoring divider, two quotient bits per stage.
`default_nettype none
module ttwm_div_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [2:0]       top_bit,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ttwm_pkg::div_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ttwm_pkg::div_t        out_data
);

  logic [2:0]     low_bit;
  logic [12:0]    dv_hi;
  logic [12:0]    dv_lo;
  logic [12:0]    rem_mid;
  logic [5:0]     quo_mid;
  ttwm_pkg::div_t step_next;

  always_comb begin
    low_bit = top_bit - 3'd1;
    dv_hi   = {6'b0, in_data.dvsr} << top_bit;
    dv_lo   = {6'b0, in_data.dvsr} << low_bit;
    step_next = in_data;
    rem_mid = in_data.rem;
    quo_mid = in_data.quo;
    if (rem_mid >= dv_hi) begin
      rem_mid = rem_mid - dv_hi;
      quo_mid = quo_mid | (6'b1 << top_bit);
    end
    step_next.rem = rem_mid;
    step_next.quo = quo_mid;
    if (rem_mid >= dv_lo) begin
      step_next.rem = rem_mid - dv_lo;
      step_next.quo = quo_mid | (6'b1 << low_bit);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= step_next;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_tiled_triangle_wipe_mask_top.sv */
// Self-checking testbench of the tiled triangle wipe mask: directed table, then random phases.
module tb_tiled_triangle_wipe_mask_top;

  // Six stages from an accepted request to its mask item; used for the settle waits.
  localparam int PIPE_DEPTH    = 6;
  // Length of the long receiver hold-off that fills the pipeline and backs up the input.
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 250;
  localparam int REPORT_LIMIT  = 10;
  // Index 3 is not a register; writes to it must be dropped by the block.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {STEP_ITEM, STEP_REG} step_kind_t;

  // One row of the directed table: either a request item or a register write.
  // Rows with pinned set carry their expected line word typed in.
  typedef struct {
    step_kind_t  kind;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [2:0]  line;
    logic [6:0]  level;
    logic [1:0]  idx;
    logic [7:0]  data;
    bit          pinned;
    logic [63:0] want;
  } step_t;

  logic clk = 1'b0;
  logic rst;

  ttwm_cfg_if  cfg_ch ();
  ttwm_req_if  req_ch ();
  ttwm_mask_if mask_ch ();

  tiled_triangle_wipe_mask_top uut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .req  (req_ch),
    .mask (mask_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Our copy of the configuration registers, updated when a write is accepted.
  logic [7:0] wipe_cx  = ttwm_pkg::CENTER_X_RST;
  logic [7:0] wipe_cy  = ttwm_pkg::CENTER_Y_RST;
  logic [6:0] wipe_max = ttwm_pkg::MAX_LEVEL_RST;

  // Line words still owed by the block, oldest first.
  logic [63:0] pending_words[$];
  int          mismatches = 0;

  // Idle rates in percent for the sender and the receiver, set per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_due = 1'b0;

  // Expected word for the item now on offer, when the table types it in.
  bit          pin_on = 1'b0;
  logic [63:0] pin_word = '0;

  step_t plan[$];

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Works out the mask word of one tile line from the current register copy.
  // The tile's offset from the centre gives a diamond distance d and a quadrant; the
  // level scales a fill index v from 0 to 15, and the line picks how many bytes of
  // the triangle are covered on this line, from the left or the right edge.
  function automatic logic [63:0] wipe_line_word(input logic [4:0] row, input logic [4:0] col,
                                                  input logic [2:0] line,
                                                  input logic [6:0] level);
    int mx, a, cx, cy, xo, yo, dx, dy, d, cdist, v, n, lref;
    bit lower, left;
    logic [63:0] ones;
    ones = '1;
    mx = (wipe_max == 7'd0) ? 1 : int'(wipe_max);
    a = int'(level);
    if (a > mx) a = mx;
    cx = int'(wipe_cx);
    cy = int'(wipe_cy);
    // Integer division truncates toward zero, as the tile offsets require.
    xo = (cx - ttwm_pkg::HALF_W) / 8;
    yo = (cy - ttwm_pkg::HALF_H) / 8;
    dx = iabs(ttwm_pkg::TILE_COLUMNS - 1 - 2 * int'(col) + 2 * xo) / 2;
    dy = iabs(ttwm_pkg::TILE_ROWS - 1 - 2 * int'(row) + 2 * yo) / 2;
    d = (dx > dy) ? dx : dy;
    lower = (int'(row) - yo) >= ttwm_pkg::TILE_ROWS / 2;
    left = (int'(col) - xo) < ttwm_pkg::TILE_COLUMNS / 2;
    dx = iabs(ttwm_pkg::HALF_W - cx);
    dy = iabs(ttwm_pkg::HALF_H - cy);
    cdist = ((dx > dy) ? dx : dy) / 8;
    v = (31 + cdist) * (mx - a) / mx + d - (15 + cdist);
    if (v < 0) v = 0;
    if (v > 15) v = 15;
    lref = lower ? 7 - int'(line) : int'(line);
    n = v - lref;
    if (n < 0) n = 0;
    if (n > 8) n = 8;
    if (n == 0) return '0;
    if (left) return ttwm_pkg::PIX_ALL & (ones >> (64 - 8 * n));
    return ttwm_pkg::PIX_ALL & (ones << (64 - 8 * n));
  endfunction

  function automatic step_t item_step(input logic [4:0] row, input logic [4:0] col,
                                      input logic [2:0] line, input logic [6:0] level,
                                      input bit pinned, input logic [63:0] want);
    step_t s;
    s = '{kind: STEP_ITEM, row: row, col: col, line: line, level: level,
          idx: ttwm_pkg::REG_CENTER_X, data: 8'd0, pinned: pinned, want: want};
    return s;
  endfunction

  function automatic step_t reg_step(input logic [1:0] idx, input logic [7:0] data);
    step_t s;
    s = '{kind: STEP_REG, row: 5'd0, col: 5'd0, line: 3'd0, level: 7'd0,
          idx: idx, data: data, pinned: 1'b0, want: '0};
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch at %0t: %s: expected %016h, got %016h", $realtime, what, want, got);
  endtask

  // Scoreboard. The output side is checked before the input side is recorded, so a
  // word that shows up with nothing owed is caught even if a request lands on the
  // same edge. Both sides are sampled at the rising edge, after the falling-edge drive.
  always @(posedge clk) begin : scoreboard
    logic [63:0] want;
    if (!rst) begin
      if (mask_ch.valid && mask_ch.ready) begin
        if (pending_words.size() == 0) begin
          report_mismatch("line word with no request waiting", '0, mask_ch.line_word);
        end else begin
          want = pending_words.pop_front();
          if (mask_ch.line_word !== want)
            report_mismatch("line_word", want, mask_ch.line_word);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pending_words.push_back(pin_on ? pin_word :
                                wipe_line_word(req_ch.tile_row, req_ch.tile_col,
                                               req_ch.line_in_tile, req_ch.level));
      end
    end
  end

  // Receiver. It stalls at the phase's rate and, when asked, holds ready low for a
  // long stretch that it counts itself; meanwhile the sender keeps offering items, so
  // all six stages fill and the request side has to stall.
  always @(negedge clk) begin : receiver
    int hold_left;
    if (hold_due) begin
      hold_due = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      mask_ch.ready <= 1'b0;
    end else begin
      mask_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one request item from a falling edge and returns at the falling edge after
  // it was taken. Valid is left high so that back-to-back items keep it up; whoever
  // stops sending lowers it.
  task automatic offer_item(input logic [4:0] row, input logic [4:0] col,
                            input logic [2:0] line, input logic [6:0] level,
                            input bit pinned, input logic [63:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.tile_row     <= row;
    req_ch.tile_col     <= col;
    req_ch.line_in_tile <= line;
    req_ch.level        <= level;
    pin_on = pinned;
    pin_word = want;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Writes one register; like offer_item it leaves valid high for the caller to drop.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      ttwm_pkg::REG_CENTER_X:  wipe_cx = data;
      ttwm_pkg::REG_CENTER_Y:  wipe_cy = data;
      ttwm_pkg::REG_MAX_LEVEL: wipe_max = data[6:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Waits until every owed word has come back, then lets the pipeline settle.
  task automatic wait_idle();
    while (pending_words.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  initial begin : stimulus
    bit cfg_open;
    int mxe;
    logic [7:0] cx, cy, ml;
    logic [6:0] lvl;
    logic [4:0] row;

    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ttwm_pkg::REG_CENTER_X;
    cfg_ch.data = 8'd0;
    req_ch.valid = 1'b0;
    req_ch.tile_row = 5'd0;
    req_ch.tile_col = 5'd0;
    req_ch.line_in_tile = 3'd0;
    req_ch.level = 7'd0;
    mask_ch.ready = 1'b0;

    // Directed table. At the reset centre, tile row 13 column 15 sits at distance 0:
    // level 0 fills the whole line, the full level and anything above it clears it.
    plan.push_back(item_step(5'd13, 5'd15, 3'd0, 7'd0,   1'b1, ttwm_pkg::PIX_ALL));
    plan.push_back(item_step(5'd13, 5'd15, 3'd0, 7'd66,  1'b1, '0));
    plan.push_back(item_step(5'd13, 5'd15, 3'd7, 7'd127, 1'b1, '0));
    // Partial triangles in all four quadrants around the centre.
    plan.push_back(item_step(5'd13, 5'd15, 3'd5, 7'd10,  1'b0, '0));
    plan.push_back(item_step(5'd13, 5'd16, 3'd5, 7'd10,  1'b0, '0));
    plan.push_back(item_step(5'd14, 5'd15, 3'd2, 7'd10,  1'b0, '0));
    plan.push_back(item_step(5'd14, 5'd16, 3'd2, 7'd10,  1'b0, '0));
    plan.push_back(item_step(5'd0,  5'd0,  3'd0, 7'd0,   1'b0, '0));
    // Rows beyond the screen run through the same formula.
    plan.push_back(item_step(5'd31, 5'd31, 3'd7, 7'd127, 1'b0, '0));
    plan.push_back(item_step(5'd28, 5'd31, 3'd4, 7'd45,  1'b0, '0));
    // Centre in the top left corner, largest level count.
    plan.push_back(reg_step(ttwm_pkg::REG_CENTER_X, 8'd0));
    plan.push_back(reg_step(ttwm_pkg::REG_CENTER_Y, 8'd0));
    plan.push_back(reg_step(ttwm_pkg::REG_MAX_LEVEL, 8'd127));
    plan.push_back(item_step(5'd0,  5'd0,  3'd0, 7'd0,   1'b0, '0));
    plan.push_back(item_step(5'd27, 5'd31, 3'd7, 7'd127, 1'b0, '0));
    plan.push_back(item_step(5'd5,  5'd9,  3'd3, 7'd64,  1'b0, '0));
    // Centre at the far corner, a single level.
    plan.push_back(reg_step(ttwm_pkg::REG_CENTER_X, 8'd255));
    plan.push_back(reg_step(ttwm_pkg::REG_CENTER_Y, 8'd255));
    plan.push_back(reg_step(ttwm_pkg::REG_MAX_LEVEL, 8'd1));
    plan.push_back(item_step(5'd31, 5'd0,  3'd6, 7'd0,   1'b0, '0));
    plan.push_back(item_step(5'd20, 5'd20, 3'd1, 7'd1,   1'b0, '0));
    // A level count of zero behaves as one: level 0 fills everything, any level
    // above zero clamps to the top and clears the line.
    plan.push_back(reg_step(ttwm_pkg::REG_MAX_LEVEL, 8'd0));
    plan.push_back(item_step(5'd13, 5'd15, 3'd3, 7'd0,   1'b1, ttwm_pkg::PIX_ALL));
    plan.push_back(item_step(5'd13, 5'd15, 3'd3, 7'd1,   1'b1, '0));
    plan.push_back(item_step(5'd2,  5'd30, 3'd0, 7'd127, 1'b1, '0));
    // The unused index is dropped, and the top data bit of max_level is ignored (5).
    plan.push_back(reg_step(REG_UNUSED, 8'hFF));
    plan.push_back(reg_step(ttwm_pkg::REG_MAX_LEVEL, 8'h85));
    plan.push_back(reg_step(ttwm_pkg::REG_CENTER_X, 8'd128));
    plan.push_back(reg_step(ttwm_pkg::REG_CENTER_Y, 8'd112));
    plan.push_back(item_step(5'd13, 5'd15, 3'd0, 7'd0,   1'b1, ttwm_pkg::PIX_ALL));
    plan.push_back(item_step(5'd13, 5'd15, 3'd0, 7'd3,   1'b0, '0));
    plan.push_back(item_step(5'd13, 5'd16, 3'd7, 7'd2,   1'b0, '0));
    plan.push_back(item_step(5'd14, 5'd0,  3'd4, 7'd1,   1'b0, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the table. Before the first write of a group the request side goes quiet
    // and the pipeline drains, so registers only change while the block is idle.
    cfg_open = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        if (!cfg_open) begin
          req_ch.valid <= 1'b0;
          wait_idle();
          cfg_open = 1'b1;
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (cfg_open) begin
          cfg_ch.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        offer_item(plan[i].row, plan[i].col, plan[i].line, plan[i].level,
                   plan[i].pinned, plan[i].want);
      end
    end

    // Random phases. Each starts from an idle block with a fresh register setting
    // and an idling pattern that cycles through none, sender only, receiver only and both.
    for (int p = 0; p < PHASES; p++) begin
      req_ch.valid <= 1'b0;
      wait_idle();
      case (p)
        1: begin cx = 8'd0;   cy = 8'd223; ml = 8'd127; end
        2: begin cx = 8'd255; cy = 8'd0;   ml = 8'd1;   end
        5: begin
          cx = ttwm_pkg::CENTER_X_RST;
          cy = ttwm_pkg::CENTER_Y_RST;
          ml = {1'b0, ttwm_pkg::MAX_LEVEL_RST};
        end
        default: begin
          cx = 8'($urandom_range(255));
          cy = 8'($urandom_range(255));
          ml = 8'($urandom_range(255));
        end
      endcase
      write_reg(ttwm_pkg::REG_CENTER_X, cx);
      write_reg(ttwm_pkg::REG_CENTER_Y, cy);
      write_reg(ttwm_pkg::REG_MAX_LEVEL, ml);
      if (p % 2 == 1) write_reg(REG_UNUSED, 8'($urandom_range(255)));
      cfg_ch.valid <= 1'b0;

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (p == 2 || p == 4) hold_due = 1'b1;

      mxe = (wipe_max == 7'd0) ? 1 : int'(wipe_max);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Mostly on-screen rows and levels within the current range, where the
        // triangles take shape; the rest covers off-screen rows and clamped levels.
        row = ($urandom_range(99) < 90) ? 5'($urandom_range(ttwm_pkg::TILE_ROWS - 1))
                                        : 5'($urandom_range(31, ttwm_pkg::TILE_ROWS));
        lvl = ($urandom_range(99) < 75) ? 7'($urandom_range(mxe)) : 7'($urandom_range(127));
        offer_item(row, 5'($urandom_range(31)), 3'($urandom_range(7)), lvl, 1'b0, '0);
      end
    end

    req_ch.valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (pending_words.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb_tiled_triangle_wipe_mask_top: done, clean");
    end else begin
      $display("tb_tiled_triangle_wipe_mask_top: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("tb_tiled_triangle_wipe_mask_top: done, errors");
    $finish;
  end

endmodule

/* tiled_triangle_wipe_mask_top.f */
hdl/ttwm_pkg.sv
hdl/ttwm_if.sv
hdl/ttwm_div_stage.sv
hdl/tiled_triangle_wipe_mask_top.sv
tb/sv/tb_tiled_triangle_wipe_mask_top.sv
